### rtl/utf8_stream_decoder_unit_macros.svh
// Assertion macros shared by the checker.
`ifndef UTF8_STREAM_DECODER_UNIT_MACROS_SVH
`define UTF8_STREAM_DECODER_UNIT_MACROS_SVH

// Clocked check, suspended while reset is held.
`define U8SD_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition that must never show on a clock edge.
`define U8SD_NEVER(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

### rtl/u8sd_pkg.sv
`default_nettype none

package u8sd_pkg;

    localparam int BUF_DEPTH = 4;
    localparam int CNT_W     = 3;

    localparam logic [20:0] REPL_CHAR = 21'h00FFFD;
    localparam logic [20:0] MIN_2B    = 21'h000080;
    localparam logic [20:0] MIN_3B    = 21'h000800;
    localparam logic [20:0] MIN_4B    = 21'h010000;
    localparam logic [20:0] MAX_CP    = 21'h10FFFF;
    localparam logic [20:0] SURR_LO   = 21'h00D800;
    localparam logic [20:0] SURR_HI   = 21'h00DFFF;

    typedef logic [7:0]  byte_t;
    typedef logic [20:0] cp_t;

    // One step of the window decoder.
    typedef struct packed {
        logic             emit;
        cp_t              cp;
        logic             bad;
        logic [CNT_W-1:0] adv;
        logic             last;
    } win_res_t;

    function automatic logic [2:0] lead_len(input byte_t b);
        logic [2:0] len;
        len = 3'd0;
        if ((b & 8'hE0) == 8'hC0)
            len = 3'd2;
        else if ((b & 8'hF0) == 8'hE0)
            len = 3'd3;
        else if ((b & 8'hF8) == 8'hF0)
            len = 3'd4;
        return len;
    endfunction

    function automatic logic is_cont(input byte_t b);
        return (b & 8'hC0) == 8'h80;
    endfunction

endpackage

`default_nettype wire

### rtl/u8sd_window.sv
`default_nettype none

// Judges the window that starts at the head of the byte buffer and looks
// ahead one window to tell whether the result is the last for this beat.
module u8sd_window (
    input  u8sd_pkg::byte_t                  buf_bytes [u8sd_pkg::BUF_DEPTH],
    input  logic [u8sd_pkg::CNT_W-1:0]       fill,
    input  logic                             fin,
    output u8sd_pkg::win_res_t               res
);
    import u8sd_pkg::*;

    byte_t            c0;
    logic [2:0]       len;
    logic             c1_ok;
    logic             c2_ok;
    logic             c3_ok;
    cp_t              cp2;
    cp_t              cp3;
    cp_t              cp4;
    logic [CNT_W-1:0] rem;
    byte_t            nxt;
    logic [2:0]       nxt_len;

    assign c0    = buf_bytes[0];
    assign len   = lead_len(c0);
    assign c1_ok = is_cont(buf_bytes[1]);
    assign c2_ok = is_cont(buf_bytes[2]);
    assign c3_ok = is_cont(buf_bytes[3]);

    assign cp2 = {10'd0, c0[4:0], buf_bytes[1][5:0]};
    assign cp3 = {5'd0, c0[3:0], buf_bytes[1][5:0], buf_bytes[2][5:0]};
    assign cp4 = {c0[2:0], buf_bytes[1][5:0], buf_bytes[2][5:0], buf_bytes[3][5:0]};

    always_comb
    begin
        res.emit = 1'b1;
        res.cp   = REPL_CHAR;
        res.bad  = 1'b1;
        res.adv  = CNT_W'(1);
        if (!c0[7])
        begin
            res.cp  = {13'd0, c0};
            res.bad = 1'b0;
        end
        else if (len == 3'd0)
        begin
            res.adv = CNT_W'(1);
        end
        else if (fill < len)
        begin
            // cut short: swallow everything at end of text, else wait
            res.emit = fin;
            res.adv  = fin ? fill : CNT_W'(0);
        end
        else
        begin
            case (len)
                3'd2:
                begin
                    if (c1_ok)
                    begin
                        res.adv = CNT_W'(2);
                        if (cp2 >= MIN_2B)
                        begin
                            res.cp  = cp2;
                            res.bad = 1'b0;
                        end
                    end
                end
                3'd3:
                begin
                    if (!c1_ok)
                        res.adv = CNT_W'(1);
                    else if (!c2_ok)
                        res.adv = CNT_W'(2);
                    else
                    begin
                        res.adv = CNT_W'(3);
                        if (cp3 >= MIN_3B && !(cp3 >= SURR_LO && cp3 <= SURR_HI))
                        begin
                            res.cp  = cp3;
                            res.bad = 1'b0;
                        end
                    end
                end
                default:
                begin
                    if (!c1_ok)
                        res.adv = CNT_W'(1);
                    else if (!c2_ok)
                        res.adv = CNT_W'(2);
                    else if (!c3_ok)
                        res.adv = CNT_W'(3);
                    else
                    begin
                        res.adv = CNT_W'(4);
                        if (cp4 >= MIN_4B && cp4 <= MAX_CP)
                        begin
                            res.cp  = cp4;
                            res.bad = 1'b0;
                        end
                    end
                end
            endcase
        end

        // Last when nothing remains, or what remains is a window still open.
        rem      = fill - res.adv;
        nxt      = buf_bytes[res.adv[1:0]];
        nxt_len  = lead_len(nxt);
        res.last = (rem == CNT_W'(0)) ||
                   (!fin && nxt_len != 3'd0 && rem < nxt_len);
    end

endmodule

`default_nettype wire

### rtl/utf8_stream_decoder_unit.sv
`default_nettype none

// Channel   Direction  Handshake                  Payload
// bytes     in         byte_valid / byte_stall    text_byte, final_byte
// results   out        result_valid / result_stall code_point, was_invalid,
//                                                 run_last, text_done
//
// A byte is loaded in ST_IDLE, then ST_RUN steps once per result; a byte
// only leaving a window open gets one step without a result. The shared
// window decoder judges one window per cycle unless a result is stalled,
// which holds it in place. byte_stall is high while a byte is worked on.
// Reset clears the pending count, the sequencer and the result valid flag.
module utf8_stream_decoder_unit (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  byte_valid,
    output logic                  byte_stall,
    input  u8sd_pkg::byte_t       text_byte,
    input  logic                  final_byte,
    output logic                  result_valid,
    input  logic                  result_stall,
    output u8sd_pkg::cp_t         code_point,
    output logic                  was_invalid,
    output logic                  run_last,
    output logic                  text_done
);
    import u8sd_pkg::*;

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_RUN  = 1'b1;

    logic             state_reg;
    logic             state_next;
    byte_t            buf_reg  [BUF_DEPTH];
    byte_t            buf_next [BUF_DEPTH];
    logic [CNT_W-1:0] fill_reg;
    logic [CNT_W-1:0] fill_next;
    logic             fin_reg;
    logic             fin_next;
    logic             res_valid_reg;
    logic             res_valid_next;
    cp_t              cp_reg;
    cp_t              cp_next;
    logic             bad_reg;
    logic             bad_next;
    logic             last_reg;
    logic             last_next;
    logic             done_reg;
    logic             done_next;
    logic             byte_take;
    logic             step_go;
    logic [CNT_W-1:0] src_idx [BUF_DEPTH];
    win_res_t         win;

    u8sd_window u_window (
        .buf_bytes (buf_reg),
        .fill      (fill_reg),
        .fin       (fin_reg),
        .res       (win)
    );

    assign byte_take = byte_valid && (state_reg == ST_IDLE);
    assign step_go   = (state_reg == ST_RUN) && (!res_valid_reg || !result_stall);

    always_comb
    begin
        for (int i = 0; i < BUF_DEPTH; i++)
            src_idx[i] = CNT_W'(i) + win.adv;
    end

    always_comb
    begin
        state_next     = state_reg;
        buf_next       = buf_reg;
        fill_next      = fill_reg;
        fin_next       = fin_reg;
        res_valid_next = res_valid_reg;
        cp_next        = cp_reg;
        bad_next       = bad_reg;
        last_next      = last_reg;
        done_next      = done_reg;

        if (res_valid_reg && !result_stall)
            res_valid_next = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (byte_take)
                begin
                    buf_next[fill_reg[1:0]] = text_byte;
                    fill_next  = fill_reg + CNT_W'(1);
                    fin_next   = final_byte;
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                if (step_go)
                begin
                    // drop the consumed bytes off the head
                    for (int i = 0; i < BUF_DEPTH; i++)
                        if (src_idx[i] < CNT_W'(BUF_DEPTH))
                            buf_next[i] = buf_reg[src_idx[i][1:0]];
                    fill_next = fill_reg - win.adv;
                    if (win.emit)
                    begin
                        res_valid_next = 1'b1;
                        cp_next        = win.cp;
                        bad_next       = win.bad;
                        last_next      = win.last;
                        done_next      = win.last && fin_reg;
                    end
                    if (!win.emit || win.last)
                        state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            fill_reg      <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        buf_reg  <= buf_next;
        fin_reg  <= fin_next;
        cp_reg   <= cp_next;
        bad_reg  <= bad_next;
        last_reg <= last_next;
        done_reg <= done_next;
    end

    assign byte_stall   = (state_reg != ST_IDLE);
    assign result_valid = res_valid_reg;
    assign code_point   = cp_reg;
    assign was_invalid  = bad_reg;
    assign run_last     = last_reg;
    assign text_done    = done_reg;

endmodule

`default_nettype wire

### rtl/u8sd_checker.sv
`default_nettype none

`include "utf8_stream_decoder_unit_macros.svh"

module u8sd_checker (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           byte_valid,
    input  wire logic           byte_stall,
    input  wire logic           result_valid,
    input  wire logic           result_stall,
    input  wire u8sd_pkg::cp_t  code_point,
    input  wire logic           was_invalid,
    input  wire logic           run_last,
    input  wire logic           text_done
);
    import u8sd_pkg::*;

    logic        byte_beat;
    logic        res_hold;
    logic [23:0] res_word;
    logic        bad_value;

    assign byte_beat = byte_valid && !byte_stall;
    assign res_hold  = result_valid && result_stall;
    assign res_word  = {code_point, was_invalid, run_last, text_done};
    assign bad_value = (was_invalid && code_point != REPL_CHAR) || code_point > MAX_CP;

    `U8SD_ASSERT(a_busy_after_beat, byte_beat |=> byte_stall, "input not held off after a beat")
    `U8SD_ASSERT(a_held_result, res_hold |=> result_valid && $stable(res_word), "held result changed")
    `U8SD_NEVER(a_done_not_last, result_valid && text_done && !run_last, "text end not last")
    `U8SD_NEVER(a_bad_value, result_valid && bad_value, "result value out of range")

endmodule

bind utf8_stream_decoder_unit u8sd_checker u_checker (.*);

`default_nettype wire

### dv/utf8_decode_scoreboard.sv
`timescale 1ns / 100ps

// Watches both channels of the decoder, predicts the code points for every
// accepted input byte, and checks every accepted output beat in order.
module utf8_decode_scoreboard (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                byte_valid,
    input  logic                byte_stall,
    input  u8sd_pkg::byte_t     text_byte,
    input  logic                final_byte,
    input  logic                result_valid,
    input  logic                result_stall,
    input  u8sd_pkg::cp_t       code_point,
    input  logic                was_invalid,
    input  logic                run_last,
    input  logic                text_done,
    output int                  fail_count,
    output int                  outstanding,
    output int                  results_seen,
    output int                  bad_seen
);

    typedef struct packed {
        u8sd_pkg::cp_t cp;
        logic          bad;
        logic          last;
        logic          done;
    } decoded_char_t;

    decoded_char_t   expected_chars[$];
    decoded_char_t   want;
    u8sd_pkg::byte_t held_bytes [0:2];
    int unsigned     held_count;
    int              errors;
    int              n_results;
    int              n_bad;

    // Length of the sequence a lead byte opens; 0 for a byte that cannot lead.
    function automatic int unsigned seq_length(input u8sd_pkg::byte_t b);
        int unsigned len;
        casez (b)
            8'b0???????: len = 1;
            8'b110?????: len = 2;
            8'b1110????: len = 3;
            8'b11110???: len = 4;
            default:     len = 0;
        endcase
        return len;
    endfunction

    function automatic decoded_char_t make_char(input u8sd_pkg::cp_t cp, input logic bad);
        decoded_char_t c;
        c.cp   = cp;
        c.bad  = bad;
        c.last = 1'b0;
        c.done = 1'b0;
        return c;
    endfunction

    task automatic decode_byte(input u8sd_pkg::byte_t b, input logic fin);
        u8sd_pkg::byte_t win [0:3];
        decoded_char_t   res [0:3];
        u8sd_pkg::byte_t c0;
        u8sd_pkg::byte_t nxt;
        u8sd_pkg::cp_t   cp;
        int unsigned     n;
        int unsigned     pos;
        int unsigned     len;
        int unsigned     k;
        int unsigned     cnt;
        logic            broke;
        n   = held_count;
        pos = 0;
        cnt = 0;
        for (k = 0; k < n; k++)
            win[k] = held_bytes[k];
        win[n] = b;
        n++;
        while (pos < n)
        begin
            c0  = win[pos];
            len = seq_length(c0);
            if (len == 0)
            begin
                res[cnt] = make_char(u8sd_pkg::REPL_CHAR, 1'b1);
                cnt++;
                pos++;
                continue;
            end
            if (n - pos < len)
            begin
                // open window: the end of text turns the whole rest into one replacement
                if (fin)
                begin
                    res[cnt] = make_char(u8sd_pkg::REPL_CHAR, 1'b1);
                    cnt++;
                    pos = n;
                end
                break;
            end
            case (len)
                1:       cp = {14'd0, c0[6:0]};
                2:       cp = {16'd0, c0[4:0]};
                3:       cp = {17'd0, c0[3:0]};
                default: cp = {18'd0, c0[2:0]};
            endcase
            broke = 1'b0;
            for (k = 1; k < len; k++)
            begin
                nxt = win[pos + k];
                if (nxt[7:6] != 2'b10)
                begin
                    // restart decoding at the offending byte
                    res[cnt] = make_char(u8sd_pkg::REPL_CHAR, 1'b1);
                    cnt++;
                    pos   = pos + k;
                    broke = 1'b1;
                    break;
                end
                cp = (cp << 6) | {15'd0, nxt[5:0]};
            end
            if (broke)
                continue;
            pos = pos + len;
            if ((len == 2 && cp < u8sd_pkg::MIN_2B) ||
                (len == 3 && cp < u8sd_pkg::MIN_3B) ||
                (len == 4 && cp < u8sd_pkg::MIN_4B) ||
                cp > u8sd_pkg::MAX_CP ||
                (cp >= u8sd_pkg::SURR_LO && cp <= u8sd_pkg::SURR_HI))
                res[cnt] = make_char(u8sd_pkg::REPL_CHAR, 1'b1);
            else
                res[cnt] = make_char(cp, 1'b0);
            cnt++;
        end
        held_count = n - pos;
        for (k = 0; k < held_count; k++)
            held_bytes[k] = win[pos + k];
        if (cnt > 0)
        begin
            res[cnt - 1].last = 1'b1;
            res[cnt - 1].done = fin;
        end
        for (k = 0; k < cnt; k++)
            expected_chars.insert(expected_chars.size(), res[k]);
    endtask

    task automatic report_mismatch(input string what, input int got, input int exp_val);
        $display("ERROR %0t: %s got 0x%0h, expected 0x%0h", $time, what, got, exp_val);
        errors++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_count   = 0;
            errors       = 0;
            n_results    = 0;
            n_bad        = 0;
            expected_chars.delete();
            fail_count   <= 0;
            outstanding  <= 0;
            results_seen <= 0;
            bad_seen     <= 0;
        end
        else
        begin
            // an output beat never stems from a byte taken at the same edge
            if (result_valid && !result_stall)
            begin
                n_results++;
                if (was_invalid)
                    n_bad++;
                if (expected_chars.size() == 0)
                    report_mismatch("unexpected result beat, code_point", code_point, 0);
                else
                begin
                    want = expected_chars.pop_front();
                    if (code_point !== want.cp)
                        report_mismatch("code_point", code_point, want.cp);
                    if (was_invalid !== want.bad)
                        report_mismatch("was_invalid", was_invalid, want.bad);
                    if (run_last !== want.last)
                        report_mismatch("run_last", run_last, want.last);
                    if (text_done !== want.done)
                        report_mismatch("text_done", text_done, want.done);
                end
            end
            if (byte_valid && !byte_stall)
                decode_byte(text_byte, final_byte);
            fail_count   <= errors;
            outstanding  <= expected_chars.size();
            results_seen <= n_results;
            bad_seen     <= n_bad;
        end
    end

endmodule

### dv/tb_top.sv
`timescale 1ns / 100ps

module tb_top;

    logic            clk = 1'b0;
    logic            rst_n;
    logic            byte_valid;
    logic            byte_stall;
    u8sd_pkg::byte_t text_byte;
    logic            final_byte;
    logic            result_valid;
    logic            result_stall = 1'b0;
    u8sd_pkg::cp_t   code_point;
    logic            was_invalid;
    logic            run_last;
    logic            text_done;

    int              fail_count;
    int              outstanding;
    int              results_seen;
    int              bad_seen;

    bit              quiet;
    bit              hold_start;
    bit              hold_done = 1'b0;
    int              hold_left = 0;
    int              bytes_sent;
    int              texts_sent;
    u8sd_pkg::byte_t text_q[$];

    utf8_stream_decoder_unit DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .byte_valid   (byte_valid),
        .byte_stall   (byte_stall),
        .text_byte    (text_byte),
        .final_byte   (final_byte),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .code_point   (code_point),
        .was_invalid  (was_invalid),
        .run_last     (run_last),
        .text_done    (text_done)
    );

    utf8_decode_scoreboard decode_check (
        .clk          (clk),
        .rst_n        (rst_n),
        .byte_valid   (byte_valid),
        .byte_stall   (byte_stall),
        .text_byte    (text_byte),
        .final_byte   (final_byte),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .code_point   (code_point),
        .was_invalid  (was_invalid),
        .run_last     (run_last),
        .text_done    (text_done),
        .fail_count   (fail_count),
        .outstanding  (outstanding),
        .results_seen (results_seen),
        .bad_seen     (bad_seen)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Output side: random stall, or a counted hold-off once one is requested.
    always @(negedge clk)
    begin
        if (hold_start && !hold_done)
        begin
            hold_left = 80;
            hold_done = 1'b1;
        end
        result_stall = (hold_left > 0) || (!quiet && $urandom_range(0, 99) < 21);
        if (hold_left > 0)
            hold_left--;
    end

    initial
    begin
        #2_000_000;
        $display("utf8_stream_decoder_unit test failed");
        $finish;
    end

    task automatic send_byte(input u8sd_pkg::byte_t b, input logic fin);
        @(negedge clk);
        while (!quiet && $urandom_range(0, 99) < 21)
        begin
            byte_valid = 1'b0;
            @(negedge clk);
        end
        byte_valid = 1'b1;
        text_byte  = b;
        final_byte = fin;
        @(posedge clk);
        while (byte_stall)
            @(posedge clk);
        bytes_sent++;
    endtask

    // Sends the queued text; the end-of-text flag rides on its last byte.
    task automatic send_text();
        int unsigned i;
        for (i = 0; i < text_q.size(); i++)
            send_byte(text_q[i], i == text_q.size() - 1);
        text_q.delete();
        texts_sent++;
    endtask

    task automatic add_byte(input u8sd_pkg::byte_t b);
        text_q.insert(text_q.size(), b);
    endtask

    // Encodes v into len bytes; bits beyond what the lead can hold are dropped.
    task automatic push_seq(input logic [20:0] v, input int unsigned len);
        case (len)
            1:
                add_byte({1'b0, v[6:0]});
            2:
            begin
                add_byte({3'b110, v[10:6]});
                add_byte({2'b10, v[5:0]});
            end
            3:
            begin
                add_byte({4'b1110, v[15:12]});
                add_byte({2'b10, v[11:6]});
                add_byte({2'b10, v[5:0]});
            end
            default:
            begin
                add_byte({5'b11110, v[20:18]});
                add_byte({2'b10, v[17:12]});
                add_byte({2'b10, v[11:6]});
                add_byte({2'b10, v[5:0]});
            end
        endcase
    endtask

    task automatic add_random_char();
        int unsigned pick;
        int unsigned len;
        logic [20:0] v;
        pick = $urandom_range(0, 99);
        if (pick < 25)
            push_seq(21'($urandom_range(0, 'h7F)), 1);
        else if (pick < 38)
            push_seq(21'($urandom_range('h80, 'h7FF)), 2);
        else if (pick < 52)
        begin
            v = 21'($urandom_range('h800, 'hFFFF));
            if (v >= 'hD800 && v <= 'hDFFF)
                v = v ^ 21'h2000;
            push_seq(v, 3);
        end
        else if (pick < 64)
            push_seq(21'($urandom_range('h10000, 'h10FFFF)), 4);
        else if (pick < 76)
        begin
            // overlong, surrogate or beyond the code space
            case ($urandom_range(0, 4))
                0:       push_seq(21'($urandom_range(0, 'h7F)), 2);
                1:       push_seq(21'($urandom_range(0, 'h7FF)), 3);
                2:       push_seq(21'($urandom_range(0, 'hFFFF)), 4);
                3:       push_seq(21'($urandom_range('hD800, 'hDFFF)), 3);
                default: push_seq(21'($urandom_range('h110000, 'h1FFFFF)), 4);
            endcase
        end
        else if (pick < 88)
            add_byte(8'($urandom_range(0, 255)));
        else
        begin
            // sequence cut short; what follows, or the end of text, closes the window
            len = $urandom_range(2, 4);
            push_seq(21'($urandom_range(0, 'h1FFFFF)), len);
            repeat ($urandom_range(1, len - 1))
                void'(text_q.pop_back());
        end
    endtask

    task automatic random_texts(input int until_bytes);
        while (bytes_sent < until_bytes)
        begin
            repeat ($urandom_range(1, 8))
                add_random_char();
            send_text();
        end
    endtask

    initial
    begin
        rst_n        = 1'b0;
        byte_valid   = 1'b0;
        text_byte    = '0;
        final_byte   = 1'b0;
        quiet        = 1'b0;
        hold_start   = 1'b0;
        bytes_sent   = 0;
        texts_sent   = 0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // ASCII extremes
        text_q = '{8'h00, 8'h7F};
        send_text();
        // three-byte euro sign, largest valid scalar
        text_q = '{8'hE2, 8'h82, 8'hAC, 8'hF4, 8'h8F, 8'hBF, 8'hBF};
        send_text();
        // overlong lead, surrogate, out-of-range lead
        text_q = '{8'hC0, 8'h80, 8'hED, 8'hA0, 8'h80, 8'hF5, 8'h80, 8'h80, 8'h80};
        send_text();
        // stray continuation, invalid lead, full window broken by ASCII
        text_q = '{8'h80, 8'hFF, 8'hF0, 8'h41, 8'h42, 8'h43};
        send_text();
        // window still open at end of text
        text_q = '{8'hE2, 8'h82};
        send_text();

        random_texts(150);
        quiet = 1'b1;
        random_texts(230);
        // output held off while input keeps coming: decoder backs up
        hold_start = 1'b1;
        random_texts(280);
        quiet = 1'b0;
        random_texts(350);

        @(negedge clk);
        byte_valid = 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        $display("Covered %0d bytes in %0d texts, %0d code points out, %0d replacements.",
                 bytes_sent, texts_sent, results_seen, bad_seen);
        $display("Mismatches: %0d.", fail_count);
        if (fail_count == 0)
            $display("utf8_stream_decoder_unit test passed");
        else
            $display("utf8_stream_decoder_unit test failed");
        $finish;
    end

endmodule
